// ===== design/segmenting_frame_encoder_sum16_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SEGMENTING_FRAME_ENCODER_SUM16_MACROS_SVH
`define SEGMENTING_FRAME_ENCODER_SUM16_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define SFE16_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define SFE16_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/sfe16_pkg.sv =====
`default_nettype none
package sfe16_pkg;

   localparam logic [7:0]  FRAME_MARK         = 8'h5A;
   localparam logic [7:0]  FRAME_OVERHEAD     = 8'd7;
   localparam logic [7:0]  SEG_MIN            = 8'd2;
   localparam logic [7:0]  SEG_MAX            = 8'd248;
   localparam logic [15:0] NODE_ID_RESET      = 16'd1;
   localparam logic [7:0]  SEGMENT_SIZE_RESET = 8'd200;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NODE_ID      = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT_SIZE = 1'b1;

   typedef struct packed {
      logic        has_header;
      logic        has_data;
      logic        has_trailer;
      logic        has_extra;
      logic [7:0]  len_byte;
      logic [15:0] node_id;
      logic [7:0]  command;
      logic [7:0]  data;
      logic [7:0]  pkt;
      logic [15:0] sum;
      logic [15:0] xsum;
   } desc_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
      logic       item_last;
   } rsp_type;

   typedef enum logic [4:0] {
      SLOT_MARK1,
      SLOT_MARK2,
      SLOT_LEN,
      SLOT_NODE_HI,
      SLOT_NODE_LO,
      SLOT_CMD,
      SLOT_DATA,
      SLOT_PKT,
      SLOT_SUM_HI,
      SLOT_SUM_LO,
      SLOT_X_MARK1,
      SLOT_X_MARK2,
      SLOT_X_LEN,
      SLOT_X_NODE_HI,
      SLOT_X_NODE_LO,
      SLOT_X_CMD,
      SLOT_X_PKT,
      SLOT_X_SUM_HI,
      SLOT_X_SUM_LO
   } slot_type;

endpackage
`default_nettype wire

// ===== design/sfe16_fifo.sv =====
`default_nettype none
module sfe16_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output logic [WIDTH-1:0]      rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

// ===== design/sfe16_front.sv =====
`default_nettype none
module sfe16_front #(
   parameter int MAX_MESSAGE = 4095
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [15:0]         node_id,
   input  wire logic [7:0]          segment_size,
   input  wire logic                req_push,
   input  wire logic [7:0]          req_payload_byte,
   input  wire logic [7:0]          req_command,
   input  wire logic [11:0]         req_message_length,
   input  wire logic                queue_full,
   output logic                     req_full,
   output logic                     desc_push,
   output sfe16_pkg::desc_type      desc
);

   localparam logic [16:0] MAX_LEN = 17'(MAX_MESSAGE);

   logic [11:0] mp_ff, mp_in;
   logic [7:0]  sp_ff, sp_in;
   logic [11:0] sn_ff, sn_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [11:0] len_ff, len_in;

   logic        accept, first, zero, split, hdr, frame_done, full_seg, msg_end;
   logic [7:0]  s, sp, cmd, count, len_byte, pkt, node_hi, node_lo;
   logic [11:0] len, len_clamped, sn, sn1, rem, mp1;
   logic [8:0]  sp1;
   logic [15:0] hdr_sum, base, data_sum, trailer_sum, xsum;

   assign req_full  = queue_full;
   assign accept    = req_push && !queue_full;
   assign desc_push = accept;
   assign node_hi   = node_id[15:8];
   assign node_lo   = node_id[7:0];

   always_comb begin
      if (segment_size < sfe16_pkg::SEG_MIN) begin
         s = sfe16_pkg::SEG_MIN;
      end else if (segment_size > sfe16_pkg::SEG_MAX) begin
         s = sfe16_pkg::SEG_MAX;
      end else begin
         s = segment_size;
      end

      len_clamped = ({5'b0, req_message_length} > MAX_LEN) ? MAX_LEN[11:0]
                                                          : req_message_length;
      first = (mp_ff == '0);
      len   = first ? len_clamped : len_ff;
      cmd   = first ? req_command : cmd_ff;
      sp    = first ? 8'd0 : sp_ff;
      sn    = first ? 12'd0 : sn_ff;
      zero  = first && (len == '0);
      split = (len > {4'b0, s});
      hdr   = (sp == '0);

      rem      = len - mp_ff;
      count    = (rem < {4'b0, s}) ? rem[7:0] : s;
      len_byte = count + sfe16_pkg::FRAME_OVERHEAD;
      hdr_sum  = 16'(len_byte) + 16'(node_hi) + 16'(node_lo) + 16'(cmd);
      xsum     = 16'(sfe16_pkg::FRAME_OVERHEAD) + 16'(node_hi) + 16'(node_lo) + 16'(cmd);
      base     = hdr ? hdr_sum : sum_ff;
      data_sum = base + 16'(req_payload_byte);

      sp1        = {1'b0, sp} + 9'd1;
      mp1        = mp_ff + 12'd1;
      sn1        = sn + 12'd1;
      msg_end    = (mp1 >= len);
      frame_done = (sp1 >= {1'b0, s}) || msg_end;
      full_seg   = split && (sp1 >= {1'b0, s});
      pkt        = (frame_done && full_seg) ? sn1[7:0] : 8'd0;
      trailer_sum = data_sum + 16'(pkt);
   end

   always_comb begin
      desc.has_header  = hdr;
      desc.has_data    = !zero;
      desc.has_trailer = zero || frame_done;
      desc.has_extra   = !zero && msg_end && frame_done && full_seg;
      desc.len_byte    = len_byte;
      desc.node_id     = node_id;
      desc.command     = cmd;
      desc.data        = req_payload_byte;
      desc.pkt         = zero ? 8'd0 : pkt;
      desc.sum         = zero ? hdr_sum : trailer_sum;
      desc.xsum        = xsum;
   end

   always_comb begin
      mp_in  = mp_ff;
      sp_in  = sp_ff;
      sn_in  = sn_ff;
      sum_in = sum_ff;
      cmd_in = cmd_ff;
      len_in = len_ff;
      if (accept) begin
         cmd_in = cmd;
         len_in = len;
         if (zero || msg_end) begin
            mp_in = '0;
            sp_in = '0;
            sn_in = '0;
         end else begin
            mp_in  = mp1;
            sp_in  = frame_done ? 8'd0 : sp1[7:0];
            sn_in  = (frame_done && full_seg) ? sn1 : sn;
            sum_in = data_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mp_ff  <= '0;
         sp_ff  <= '0;
         sn_ff  <= '0;
         sum_ff <= '0;
         cmd_ff <= '0;
         len_ff <= '0;
      end else begin
         mp_ff  <= mp_in;
         sp_ff  <= sp_in;
         sn_ff  <= sn_in;
         sum_ff <= sum_in;
         cmd_ff <= cmd_in;
         len_ff <= len_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/sfe16_back.sv =====
`default_nettype none
module sfe16_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 desc_empty,
   input  wire sfe16_pkg::desc_type  desc,
   output logic                      desc_pop,
   input  wire logic                 rsp_full,
   output logic                      rsp_push,
   output sfe16_pkg::rsp_type        rsp
);

   sfe16_pkg::desc_type cur_ff, cur_in;
   sfe16_pkg::slot_type slot_ff, slot_in, slot_next;
   logic                valid_ff, valid_in;
   logic                last, emit, load;

   always_comb begin
      slot_next = slot_ff;
      case (slot_ff)
         sfe16_pkg::SLOT_MARK1:     slot_next = sfe16_pkg::SLOT_MARK2;
         sfe16_pkg::SLOT_MARK2:     slot_next = sfe16_pkg::SLOT_LEN;
         sfe16_pkg::SLOT_LEN:       slot_next = sfe16_pkg::SLOT_NODE_HI;
         sfe16_pkg::SLOT_NODE_HI:   slot_next = sfe16_pkg::SLOT_NODE_LO;
         sfe16_pkg::SLOT_NODE_LO:   slot_next = sfe16_pkg::SLOT_CMD;
         sfe16_pkg::SLOT_CMD:       slot_next = cur_ff.has_data ? sfe16_pkg::SLOT_DATA
                                                                : sfe16_pkg::SLOT_PKT;
         sfe16_pkg::SLOT_DATA:      slot_next = sfe16_pkg::SLOT_PKT;
         sfe16_pkg::SLOT_PKT:       slot_next = sfe16_pkg::SLOT_SUM_HI;
         sfe16_pkg::SLOT_SUM_HI:    slot_next = sfe16_pkg::SLOT_SUM_LO;
         sfe16_pkg::SLOT_SUM_LO:    slot_next = sfe16_pkg::SLOT_X_MARK1;
         sfe16_pkg::SLOT_X_MARK1:   slot_next = sfe16_pkg::SLOT_X_MARK2;
         sfe16_pkg::SLOT_X_MARK2:   slot_next = sfe16_pkg::SLOT_X_LEN;
         sfe16_pkg::SLOT_X_LEN:     slot_next = sfe16_pkg::SLOT_X_NODE_HI;
         sfe16_pkg::SLOT_X_NODE_HI: slot_next = sfe16_pkg::SLOT_X_NODE_LO;
         sfe16_pkg::SLOT_X_NODE_LO: slot_next = sfe16_pkg::SLOT_X_CMD;
         sfe16_pkg::SLOT_X_CMD:     slot_next = sfe16_pkg::SLOT_X_PKT;
         sfe16_pkg::SLOT_X_PKT:     slot_next = sfe16_pkg::SLOT_X_SUM_HI;
         sfe16_pkg::SLOT_X_SUM_HI:  slot_next = sfe16_pkg::SLOT_X_SUM_LO;
         default:                   slot_next = sfe16_pkg::SLOT_MARK1;
      endcase
   end

   always_comb begin
      rsp.frame_byte = sfe16_pkg::FRAME_MARK;
      rsp.frame_end  = 1'b0;
      case (slot_ff)
         sfe16_pkg::SLOT_MARK1,
         sfe16_pkg::SLOT_MARK2,
         sfe16_pkg::SLOT_X_MARK1,
         sfe16_pkg::SLOT_X_MARK2:   rsp.frame_byte = sfe16_pkg::FRAME_MARK;
         sfe16_pkg::SLOT_LEN:       rsp.frame_byte = cur_ff.len_byte;
         sfe16_pkg::SLOT_X_LEN:     rsp.frame_byte = sfe16_pkg::FRAME_OVERHEAD;
         sfe16_pkg::SLOT_NODE_HI,
         sfe16_pkg::SLOT_X_NODE_HI: rsp.frame_byte = cur_ff.node_id[15:8];
         sfe16_pkg::SLOT_NODE_LO,
         sfe16_pkg::SLOT_X_NODE_LO: rsp.frame_byte = cur_ff.node_id[7:0];
         sfe16_pkg::SLOT_CMD,
         sfe16_pkg::SLOT_X_CMD:     rsp.frame_byte = cur_ff.command;
         sfe16_pkg::SLOT_DATA:      rsp.frame_byte = cur_ff.data;
         sfe16_pkg::SLOT_PKT:       rsp.frame_byte = cur_ff.pkt;
         sfe16_pkg::SLOT_X_PKT:     rsp.frame_byte = 8'd0;
         sfe16_pkg::SLOT_SUM_HI:    rsp.frame_byte = cur_ff.sum[15:8];
         sfe16_pkg::SLOT_SUM_LO: begin
            rsp.frame_byte = cur_ff.sum[7:0];
            rsp.frame_end  = 1'b1;
         end
         sfe16_pkg::SLOT_X_SUM_HI:  rsp.frame_byte = cur_ff.xsum[15:8];
         sfe16_pkg::SLOT_X_SUM_LO: begin
            rsp.frame_byte = cur_ff.xsum[7:0];
            rsp.frame_end  = 1'b1;
         end
         default:                   rsp.frame_byte = sfe16_pkg::FRAME_MARK;
      endcase
      last = ((slot_ff == sfe16_pkg::SLOT_DATA) && !cur_ff.has_trailer) ||
             ((slot_ff == sfe16_pkg::SLOT_SUM_LO) && !cur_ff.has_extra) ||
             (slot_ff == sfe16_pkg::SLOT_X_SUM_LO);
      rsp.item_last = last;
   end

   assign emit     = valid_ff && !rsp_full;
   assign rsp_push = emit;
   assign load     = !desc_empty && (!valid_ff || (emit && last));
   assign desc_pop = load;

   always_comb begin
      cur_in   = cur_ff;
      slot_in  = slot_ff;
      valid_in = valid_ff;
      if (load) begin
         cur_in   = desc;
         slot_in  = desc.has_header ? sfe16_pkg::SLOT_MARK1 : sfe16_pkg::SLOT_DATA;
         valid_in = 1'b1;
      end else if (emit && last) begin
         valid_in = 1'b0;
      end else if (emit) begin
         slot_in = slot_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= sfe16_pkg::SLOT_MARK1;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule
`default_nettype wire

// ===== design/segmenting_frame_encoder_sum16.sv =====
// Segmenting frame encoder. Payload bytes of a message enter on the req_ queue port, one
// beat per byte, each carrying the message command and total length (read on the first
// beat of a message). A zero-length message takes one beat and yields one empty frame.
// Encoded frame bytes leave on the rsp_ queue port, oldest first, flagged with frame_end
// on the low checksum byte and item_last on the last byte caused by an input beat.
// The front stage classifies each beat combinationally and queues a short descriptor; the
// back stage turns a descriptor into 1 to 13 output bytes at one byte per cycle while the
// output queue has room, so a payload byte in the middle of a frame costs one output byte;
// a byte that opens or closes a frame adds its 6 header or 3 trailer bytes, and the final
// byte of a split message that ends on a full segment adds a 9-byte empty frame. The back
// stage's byte rate is what sets throughput; the descriptor queue lets the front run ahead
// by DESC_DEPTH beats. When idle, a beat's first result byte passes the descriptor queue,
// the back stage's descriptor register and the output queue before it is on the rsp_ ports.
// Synchronous reset empties both queues and clears the message state; node_id returns
// to 1 and segment_size to 200. The csr_ port is always ready and should be written only
// while the block is idle. When the receiver stops popping, the output queue fills, the
// back stage holds, then the descriptor queue fills and req_full rises.
`default_nettype none
module segmenting_frame_encoder_sum16 #(
   parameter int MAX_MESSAGE = 4095,
   parameter int DESC_DEPTH  = 4,
   parameter int RSP_DEPTH   = 2
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   output logic                                    req_full,
   input  wire logic [7:0]                         req_payload_byte,
   input  wire logic [7:0]                         req_command,
   input  wire logic [11:0]                        req_message_length,
   output logic                                    rsp_empty,
   input  wire logic                               rsp_pop,
   output logic [7:0]                              rsp_frame_byte,
   output logic                                    rsp_frame_end,
   output logic                                    rsp_item_last,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [sfe16_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [15:0]                        csr_wdata
);

   localparam int DESC_W = $bits(sfe16_pkg::desc_type);
   localparam int RSP_W  = $bits(sfe16_pkg::rsp_type);

   logic [15:0]         node_id_ff;
   logic [7:0]          seg_size_ff;
   logic                dq_full, dq_empty, dq_push, dq_pop;
   logic                rq_full, rq_push;
   sfe16_pkg::desc_type dq_wdata, dq_rdata;
   sfe16_pkg::rsp_type  rq_wdata, rq_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff  <= sfe16_pkg::NODE_ID_RESET;
         seg_size_ff <= sfe16_pkg::SEGMENT_SIZE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            sfe16_pkg::CSR_NODE_ID:      node_id_ff  <= csr_wdata;
            sfe16_pkg::CSR_SEGMENT_SIZE: seg_size_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   sfe16_front #(
      .MAX_MESSAGE(MAX_MESSAGE)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .node_id            (node_id_ff),
      .segment_size       (seg_size_ff),
      .req_push           (req_push),
      .req_payload_byte   (req_payload_byte),
      .req_command        (req_command),
      .req_message_length (req_message_length),
      .queue_full         (dq_full),
      .req_full           (req_full),
      .desc_push          (dq_push),
      .desc               (dq_wdata)
   );

   sfe16_fifo #(
      .WIDTH(DESC_W),
      .DEPTH(DESC_DEPTH)
   ) u_desc_q (
      .clock (clock),
      .reset (reset),
      .push  (dq_push),
      .wdata (dq_wdata),
      .pop   (dq_pop),
      .full  (dq_full),
      .empty (dq_empty),
      .rdata (dq_rdata)
   );

   sfe16_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_empty (dq_empty),
      .desc       (dq_rdata),
      .desc_pop   (dq_pop),
      .rsp_full   (rq_full),
      .rsp_push   (rq_push),
      .rsp        (rq_wdata)
   );

   sfe16_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(RSP_DEPTH)
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rq_push),
      .wdata (rq_wdata),
      .pop   (rsp_pop),
      .full  (rq_full),
      .empty (rsp_empty),
      .rdata (rq_rdata)
   );

   assign rsp_frame_byte = rq_rdata.frame_byte;
   assign rsp_frame_end  = rq_rdata.frame_end;
   assign rsp_item_last  = rq_rdata.item_last;

endmodule
`default_nettype wire

// ===== design/sfe16_checker.sv =====
`default_nettype none
`include "segmenting_frame_encoder_sum16_macros.svh"
module sfe16_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic [7:0] rsp_frame_byte,
   input wire logic       rsp_frame_end,
   input wire logic       rsp_item_last
);

   logic [7:0] cnt_ff, cnt_in;
   logic       beat;

   assign beat = rsp_pop && !rsp_empty;

   always_comb begin
      cnt_in = cnt_ff;
      if (beat && rsp_frame_end) begin
         cnt_in = '0;
      end else if (beat && (cnt_ff != 8'hFF)) begin
         cnt_in = cnt_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   `SFE16_ASSERT_NR(a_reset_empty, clock, reset |=> rsp_empty, "Result queue not empty after reset.")
   `SFE16_ASSERT(a_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_frame_byte)), "Waiting beat changed or vanished.")
   `SFE16_ASSERT(a_marks, clock, reset, (beat && (cnt_ff < 8'd2)) |-> (rsp_frame_byte == sfe16_pkg::FRAME_MARK), "Frame does not open with two marks.")
   `SFE16_ASSERT(a_frame_len, clock, reset, (beat && rsp_frame_end) |-> (cnt_ff >= 8'd8), "Frame ended before a full header and trailer.")
   `SFE16_ASSERT(a_last_pos, clock, reset, (beat && rsp_item_last && !rsp_frame_end) |-> (cnt_ff >= 8'd6), "Item ended inside a frame header.")

endmodule

bind segmenting_frame_encoder_sum16 sfe16_checker u_sfe16_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_frame_byte (rsp_frame_byte),
   .rsp_frame_end  (rsp_frame_end),
   .rsp_item_last  (rsp_item_last)
);
`default_nettype wire
